[hdl/urm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_pkg - shared types and constants of the ultrasonic range meter
// Item, result and register write layouts, phase codes, fixed-point scale
// constants and the decimal conversion constants.
// ----------------------------------------------------------------------------
package urm_pkg;

    // Default echo counter width.
    localparam int URM_COUNT_WIDTH = 16;

    // Register file.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_TICKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MILLI   = 1'd1;

    localparam int TRIG_W = 8;
    localparam int SCALE_W = 16;
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RESET = 8'd10;
    localparam logic [SCALE_W-1:0] SCALE_MILLI_RESET   = 16'd1866;

    // Item kinds and sensor select.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_START   = 1'b1;
    localparam logic SENSOR_FRONT = 1'b0;
    localparam logic SENSOR_BACK  = 1'b1;

    // Measurement phases.
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TRIG  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_COUNT = 2'd3;

    // Distance scaling: floor(count * scale / 100000), saturated to 2047.
    localparam int DIST_W = 11;
    localparam int unsigned SCALE_DEN   = 100000;
    localparam int unsigned DIST_MAX    = 2047;
    localparam int unsigned SAT_PRODUCT = (DIST_MAX + 1) * SCALE_DEN;
    localparam int SAT_W = 28;                  // bits of a product below SAT_PRODUCT
    // 100000 = 32 * 3125: drop five bits, then multiply by ceil(2^36 / 3125).
    localparam int PRE_SHIFT    = 5;
    localparam int QUOT_IN_W    = SAT_W - PRE_SHIFT;
    localparam int RECIP_SHIFT  = 36;
    localparam int RECIP_W      = 25;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 25'd21990233;
    localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;

    // Decimal digits: x / 100 = (x * 5243) >> 19, x / 10 = (x * 205) >> 11.
    localparam int DIV100_PROD_W = 24;
    localparam int DIV100_SHIFT  = 19;
    localparam logic [DIV100_PROD_W-1:0] DIV100_MULT = 24'd5243;
    localparam int DIV10_PROD_W = 15;
    localparam int DIV10_SHIFT  = 11;
    localparam logic [DIV10_PROD_W-1:0] DIV10_MULT = 15'd205;
    localparam int unsigned DEC_BASE    = 10;
    localparam int unsigned DEC_HUNDRED = 100;

    localparam int DIGIT_W = 6;
    localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;
    localparam int TAG_W = 7;
    localparam logic [TAG_W-1:0] TAG_FRONT = 7'd68;   // 'D'
    localparam logic [TAG_W-1:0] TAG_BACK  = 7'd100;  // 'd'

    typedef struct packed {
        logic kind;
        logic sensor;
        logic echo_front;
        logic echo_back;
    } urm_item_t;

    typedef struct packed {
        logic                trigger_front;
        logic                trigger_back;
        logic                busy_res;
        logic                done_res;
        logic [DIST_W-1:0]   distance_cm;
        logic [TAG_W-1:0]    tag_char;
        logic [DIGIT_W-1:0]  digit_thousands;
        logic [DIGIT_W-1:0]  digit_hundreds;
        logic [DIGIT_W-1:0]  digit_tens;
        logic [DIGIT_W-1:0]  digit_ones;
    } urm_result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  data;
    } urm_cfg_t;

    // Per-item control flags carried down the result pipeline.
    typedef struct packed {
        logic trig_front;
        logic trig_back;
        logic busy;
        logic done;
        logic sensor;
    } urm_flags_t;

endpackage

[hdl/urm_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_stream_if - valid/ready channel
// One transfer happens at each rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface urm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ultrasonic_range_meter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_meter - two-channel ultrasonic ranger controller
// Trigger/echo sequencing for a front and a back ranger, echo timing,
// distance scaling and ASCII formatting of each reading.
// ----------------------------------------------------------------------------
// Every transfer on item is one tick of the time base or a start request, and
// produces exactly one transfer on result. The block takes one item per clock
// while result is not stalled: the phase sequencer updates in the cycle of the
// transfer, and the result walks a five-stage pipeline (flags, count x scale
// multiply, reciprocal multiply for the divide by 100000, saturation and
// distance hold, decimal digits) into the result register.
// Stages that hold no result fill up while result is stalled, so up to four
// items can be taken behind a waiting result, five in flight in all. Register
// writes on cfg_wr are always taken; change them only while no measurement is
// in flight.
// ----------------------------------------------------------------------------
module ultrasonic_range_meter #(
    parameter int COUNT_WIDTH = urm_pkg::URM_COUNT_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    urm_stream_if.sink     item,
    urm_stream_if.source   result,
    urm_stream_if.sink     cfg_wr
);
    import urm_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + SCALE_W;
    localparam int EXT_W  = (PROD_W > SAT_W) ? PROD_W : SAT_W;

    // Configuration registers.
    logic [TRIG_W-1:0]  trigger_ticks_reg;
    logic [SCALE_W-1:0] scale_milli_reg;

    // Measurement sequencer state.
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic                   chosen_reg, chosen_next;
    logic [COUNT_WIDTH-1:0] echo_ticks_reg, echo_ticks_next;
    logic [TRIG_W-1:0]      pulse_ticks_reg, pulse_ticks_next;
    logic                   last_sensor_reg, last_sensor_next;
    logic [DIST_W-1:0]      last_dist_reg;

    // Pipeline stages.
    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                   rdy1, rdy2, rdy3, rdy4, rdy5;
    urm_flags_t             flags_next;
    urm_flags_t             flags1_reg, flags2_reg, flags3_reg, flags4_reg;
    logic [COUNT_WIDTH-1:0] count1_reg;
    logic [PROD_W-1:0]      prod2_reg;
    logic                   sat3_reg;
    logic [RECIP_PROD_W-1:0] recip3_reg;
    logic [DIST_W-1:0]      dist4_reg;
    urm_result_t            result_reg;

    logic                   item_xfer;
    logic                   echo_sel;
    logic [TRIG_W-1:0]      trig_len;
    logic [EXT_W-1:0]       prod_ext;
    logic [QUOT_IN_W-1:0]   quot_in;
    logic [DIST_W-1:0]      dist_new;
    logic [DIST_W-1:0]      dist_in;

    // Digit conversion.
    logic [DIV100_PROD_W-1:0] q100_prod;
    logic [4:0]               q100;
    logic [1:0]               dig_th;
    logic [3:0]               dig_hu;
    logic [6:0]               r100;
    logic [DIV10_PROD_W-1:0]  q10_prod;
    logic [3:0]               dig_te;
    logic [3:0]               dig_on;

    // ------------------------------------------------------------------
    // Register writes: always accepted.
    // ------------------------------------------------------------------
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RESET;
            scale_milli_reg   <= SCALE_MILLI_RESET;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.payload.reg_index)
                REG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_wr.payload.data[TRIG_W-1:0];
                REG_SCALE_MILLI:   scale_milli_reg   <= cfg_wr.payload.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ready chain: a stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------
    assign rdy5 = !v5_reg || result.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign item.ready = rdy1;
    assign item_xfer  = item.valid && rdy1;

    // ------------------------------------------------------------------
    // Phase sequencer: runs once per accepted item.
    // ------------------------------------------------------------------
    assign echo_sel = (chosen_reg == SENSOR_BACK) ? item.payload.echo_back
                                                  : item.payload.echo_front;
    // A zero trigger length acts as one tick.
    assign trig_len = (trigger_ticks_reg == '0) ? TRIG_W'(1) : trigger_ticks_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        chosen_next      = chosen_reg;
        echo_ticks_next  = echo_ticks_reg;
        pulse_ticks_next = pulse_ticks_reg;
        last_sensor_next = last_sensor_reg;
        flags_next       = '0;

        if (item.payload.kind == KIND_START)
        begin
            // Start while busy is dropped.
            if (phase_reg == PH_IDLE)
            begin
                chosen_next      = item.payload.sensor;
                echo_ticks_next  = '0;
                pulse_ticks_next = '0;
                phase_next       = PH_TRIG;
            end
        end
        else
        begin
            case (phase_reg)
                PH_TRIG:
                begin
                    flags_next.trig_front = (chosen_reg == SENSOR_FRONT);
                    flags_next.trig_back  = (chosen_reg == SENSOR_BACK);
                    pulse_ticks_next      = pulse_ticks_reg + TRIG_W'(1);
                    if (pulse_ticks_next >= trig_len)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (echo_sel)
                    begin
                        echo_ticks_next = COUNT_WIDTH'(1);
                        phase_next      = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (echo_sel)
                    begin
                        echo_ticks_next = echo_ticks_reg + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        last_sensor_next = chosen_reg;
                        flags_next.done  = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end

        flags_next.busy   = (phase_next != PH_IDLE);
        flags_next.sensor = last_sensor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            chosen_reg      <= SENSOR_FRONT;
            echo_ticks_reg  <= '0;
            pulse_ticks_reg <= '0;
            last_sensor_reg <= SENSOR_FRONT;
        end
        else if (item_xfer)
        begin
            phase_reg       <= phase_next;
            chosen_reg      <= chosen_next;
            echo_ticks_reg  <= echo_ticks_next;
            pulse_ticks_reg <= pulse_ticks_next;
            last_sensor_reg <= last_sensor_next;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of the result pipeline.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= item.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: flags and the echo count as it stood before the item.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            flags1_reg <= flags_next;
            count1_reg <= echo_ticks_reg;
        end
    end

    // Stage 2: count times scale.
    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            flags2_reg <= flags1_reg;
            prod2_reg  <= PROD_W'(count1_reg) * PROD_W'(scale_milli_reg);
        end
    end

    // Stage 3: saturation check and reciprocal multiply for / 100000.
    assign prod_ext = EXT_W'(prod2_reg);
    assign quot_in  = prod_ext[SAT_W-1:PRE_SHIFT];

    always_ff @(posedge clk)
    begin
        if (v2_reg && rdy3)
        begin
            flags3_reg <= flags2_reg;
            sat3_reg   <= (prod_ext >= EXT_W'(SAT_PRODUCT));
            recip3_reg <= RECIP_PROD_W'(quot_in) * RECIP_PROD_W'(RECIP_MULT);
        end
    end

    // Stage 4: resolve the distance; hold the last reading for other items.
    assign dist_new = sat3_reg ? DIST_W'(DIST_MAX) : recip3_reg[RECIP_SHIFT +: DIST_W];
    assign dist_in  = flags3_reg.done ? dist_new : last_dist_reg;

    always_ff @(posedge clk)
    begin
        if (v3_reg && rdy4)
        begin
            flags4_reg <= flags3_reg;
            dist4_reg  <= dist_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_dist_reg <= '0;
        end
        else if (v3_reg && rdy4 && flags3_reg.done)
        begin
            last_dist_reg <= dist_new;
        end
    end

    // Stage 5: decimal digits into the result register.
    always_comb
    begin
        q100_prod = DIV100_PROD_W'(dist4_reg) * DIV100_MULT;
        q100      = q100_prod[DIV100_SHIFT +: 5];
        if (q100 >= 5'(2 * DEC_BASE))
        begin
            dig_th = 2'd2;
        end
        else if (q100 >= 5'(DEC_BASE))
        begin
            dig_th = 2'd1;
        end
        else
        begin
            dig_th = 2'd0;
        end
        dig_hu   = 4'(q100 - 5'(dig_th) * 5'(DEC_BASE));
        r100     = 7'(dist4_reg - DIST_W'(q100) * DIST_W'(DEC_HUNDRED));
        q10_prod = DIV10_PROD_W'(r100) * DIV10_MULT;
        dig_te   = q10_prod[DIV10_SHIFT +: 4];
        dig_on   = 4'(r100 - 7'(dig_te) * 7'(DEC_BASE));
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg && rdy5)
        begin
            result_reg.trigger_front   <= flags4_reg.trig_front;
            result_reg.trigger_back    <= flags4_reg.trig_back;
            result_reg.busy_res        <= flags4_reg.busy;
            result_reg.done_res        <= flags4_reg.done;
            result_reg.distance_cm     <= dist4_reg;
            result_reg.tag_char        <= (flags4_reg.sensor == SENSOR_BACK) ? TAG_BACK
                                                                             : TAG_FRONT;
            result_reg.digit_thousands <= ASCII_ZERO + DIGIT_W'(dig_th);
            result_reg.digit_hundreds  <= ASCII_ZERO + DIGIT_W'(dig_hu);
            result_reg.digit_tens      <= ASCII_ZERO + DIGIT_W'(dig_te);
            result_reg.digit_ones      <= ASCII_ZERO + DIGIT_W'(dig_on);
        end
    end

    assign result.valid   = v5_reg;
    assign result.payload = result_reg;

endmodule

[hdl/urm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_checker - port-level assertions for the ultrasonic range meter
// Watches the result channel, checks that a stalled result holds, and checks flag and digit consistency.
// ----------------------------------------------------------------------------
module urm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input urm_pkg::urm_result_t result_payload
);
    import urm_pkg::*;

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_payload))
    else $error("result dropped or changed while stalled");

    // A finished reading ends the measurement and drives no trigger.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_payload.done_res |->
            !result_payload.busy_res && !result_payload.trigger_front
            && !result_payload.trigger_back)
    else $error("done result shows busy or trigger");

    // At most one trigger, and only during a measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_payload.trigger_front || result_payload.trigger_back) |->
            result_payload.busy_res
            && !(result_payload.trigger_front && result_payload.trigger_back))
    else $error("bad trigger drive");

    // Thousands digit agrees with the binary distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result_payload.distance_cm >= DIST_W'(1000))
            == (result_payload.digit_thousands != ASCII_ZERO))
    else $error("thousands digit does not match distance");

endmodule

bind ultrasonic_range_meter urm_checker u_urm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);
